@@ rtl/core/rc4_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, channel widths and the microcode table of the RC4 core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_LEN_W   = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN  = 2'd2;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_DATA     = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_FILL = 4'd1;
  localparam step_t STEP_K0   = 4'd2;
  localparam step_t STEP_K1   = 4'd3;
  localparam step_t STEP_K2   = 4'd4;
  localparam step_t STEP_K3   = 4'd5;
  localparam step_t STEP_KEND = 4'd6;
  localparam step_t STEP_D0   = 4'd7;
  localparam step_t STEP_D1   = 4'd8;
  localparam step_t STEP_D2   = 4'd9;
  localparam step_t STEP_D3   = 4'd10;
  localparam step_t STEP_D4   = 4'd11;
  localparam step_t STEP_ERR  = 4'd12;
  localparam step_t STEP_LAST = STEP_ERR;

  typedef enum logic [1:0] {WA_N, WA_I, WA_J} wa_sel_t;
  typedef enum logic [1:0] {WD_N, WD_RDATA, WD_SI} wd_sel_t;
  typedef enum logic [1:0] {RA_N, RA_I_NXT, RA_J_NXT, RA_T} ra_sel_t;
  typedef enum logic [1:0] {J_HOLD, J_KSA, J_PRG} j_op_t;
  typedef enum logic [1:0] {JC_NEXT, JC_ALWAYS, JC_N_NOT_MAX, JC_DISPATCH} jc_t;

  typedef struct packed {
    logic    we;
    wa_sel_t wa;
    wd_sel_t wd;
    ra_sel_t ra;
    j_op_t   jop;
    logic    i_inc;
    logic    n_inc;
    logic    k_inc;
    logic    si_ld;
    logic    sj_ld;
    logic    byp_ld;
    logic    emit;
    logic    emit_err;
    logic    finish;
    jc_t     jc;
    step_t   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    w.wa = WA_N;
    w.wd = WD_N;
    w.ra = RA_N;
    w.jop = J_HOLD;
    w.jc = JC_NEXT;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.jc = JC_DISPATCH;
      end
      STEP_FILL: begin
        w.we = 1'b1;
        w.n_inc = 1'b1;
        w.jc = JC_N_NOT_MAX;
        w.target = STEP_FILL;
      end
      STEP_K0: begin
        w.ra = RA_N;
      end
      STEP_K1: begin
        w.jop = J_KSA;
        w.si_ld = 1'b1;
        w.ra = RA_J_NXT;
      end
      STEP_K2: begin
        w.we = 1'b1;
        w.wa = WA_N;
        w.wd = WD_RDATA;
      end
      STEP_K3: begin
        w.we = 1'b1;
        w.wa = WA_J;
        w.wd = WD_SI;
        w.n_inc = 1'b1;
        w.k_inc = 1'b1;
        w.jc = JC_N_NOT_MAX;
        w.target = STEP_K0;
      end
      STEP_KEND: begin
        w.finish = 1'b1;
        w.jc = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_D0: begin
        w.i_inc = 1'b1;
        w.ra = RA_I_NXT;
      end
      STEP_D1: begin
        w.jop = J_PRG;
        w.si_ld = 1'b1;
        w.ra = RA_J_NXT;
      end
      STEP_D2: begin
        w.we = 1'b1;
        w.wa = WA_I;
        w.wd = WD_RDATA;
        w.sj_ld = 1'b1;
      end
      STEP_D3: begin
        w.we = 1'b1;
        w.wa = WA_J;
        w.wd = WD_SI;
        w.ra = RA_T;
        w.byp_ld = 1'b1;
      end
      STEP_D4: begin
        w.ra = RA_T;
        w.emit = 1'b1;
        w.jc = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_ERR: begin
        w.emit_err = 1'b1;
        w.jc = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rc4_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_in_if
// Input channel of the RC4 core: operation, data byte and end-of-message mark.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [rc4_pkg::BYTE_W-1:0]  data_in;
  logic                        last_byte;

  modport source (output valid, output op, output data_in, output last_byte, input ready);
  modport sink   (input valid, input op, input data_in, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rc4_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_out_if
// Result channel of the RC4 core: processed byte, end mark and key status.
// ----------------------------------------------------------------------------
interface rc4_out_if;
  logic                        valid;
  logic                        ready;
  logic [rc4_pkg::BYTE_W-1:0]  data_out;
  logic                        last_out;
  logic                        not_keyed;

  modport source (output valid, output data_out, output last_out, output not_keyed,
                  input ready);
  modport sink   (input valid, input data_out, input last_out, input not_keyed,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/rc4_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_cfg_if
// Register write channel of the RC4 core: register index and write data.
// ----------------------------------------------------------------------------
interface rc4_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rc4_pkg::CFG_INDEX_W-1:0]  index;
  logic [rc4_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rc4_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ram
// Generic memory with one write port and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/rc4_stream_cipher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 core run by a small microprogram over a 256-byte permutation memory.
//
//   Channel  Direction  Payload                          Transaction
//   in_ch    sink       op, data_in, last_byte           one key schedule or data byte
//   out_ch   source     data_out, last_out, not_keyed    one result per data byte
//   cfg_ch   sink       index, data                      one register write
//
// A data byte runs through steps D0 to D4 before the core takes the next input; its
// result is registered at step D4. The swap needs two reads and two
// writes plus the keystream read on the single read and single write port.
// A key schedule runs a fill pass, then one swap step per entry through K0 to K3.
// Reset is synchronous; the permutation memory has no reset and no clearing pass.
// A full output register that is not taken holds the sequencer at the result step.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  rc4_in_if.sink   in_ch,
  rc4_out_if.source out_ch,
  rc4_cfg_if.sink  cfg_ch
);

  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KD = 1 << KW;
  localparam int AW = $clog2(rc4_pkg::TABLE_DEPTH);

  rc4_pkg::ucode_t uc;

  rc4_pkg::step_t step_r, step_nxt;
  logic [AW-1:0]  n_r, n_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic [7:0]     si_r, sj_r;
  logic           byp_r;
  logic           keyed_r;
  logic [7:0]     din_r;
  logic           last_r;

  logic [7:0]     key_r [KD];
  logic [rc4_pkg::KEY_LEN_W-1:0] klen_r;
  logic [KW:0]    len_eff;
  logic [KW:0]    k_plus;

  logic           out_valid_r;
  logic [7:0]     out_data_r;
  logic           out_last_r;
  logic           out_nk_r;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic [7:0]     t_addr;
  logic [7:0]     ks;

  logic           in_accept;
  logic           cfg_accept;
  logic           out_free;
  logic           hold;

  assign uc         = rc4_pkg::ucode_rom(step_r);
  assign in_ch.ready = (step_r == rc4_pkg::STEP_IDLE);
  assign in_accept  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_accept = cfg_ch.valid && cfg_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign hold       = (uc.emit || uc.emit_err) && !out_free;

  assign t_addr = si_r + sj_r;
  assign ks     = byp_r ? si_r : ram_rdata;

  always_comb begin
    priority if (klen_r == '0) begin
      len_eff = (KW+1)'(1);
    end else if (klen_r > rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
      len_eff = (KW+1)'(MAX_KEY_BYTES);
    end else begin
      len_eff = klen_r[KW:0];
    end
  end

  assign k_plus = {1'b0, k_r} + 1'b1;

  always_comb begin
    unique case (uc.jop)
      rc4_pkg::J_KSA: j_nxt = j_r + ram_rdata + key_r[k_r];
      rc4_pkg::J_PRG: j_nxt = j_r + ram_rdata;
      default:        j_nxt = j_r;
    endcase
    if (in_accept && (in_ch.op == rc4_pkg::OP_SCHEDULE)) begin
      j_nxt = '0;
    end
  end

  always_comb begin
    unique case (uc.wa)
      rc4_pkg::WA_I: ram_waddr = i_r;
      rc4_pkg::WA_J: ram_waddr = j_r;
      default:       ram_waddr = n_r;
    endcase
    unique case (uc.wd)
      rc4_pkg::WD_RDATA: ram_wdata = ram_rdata;
      rc4_pkg::WD_SI:    ram_wdata = si_r;
      default:           ram_wdata = n_r;
    endcase
    unique case (uc.ra)
      rc4_pkg::RA_N:     ram_raddr = n_r;
      rc4_pkg::RA_I_NXT: ram_raddr = i_r + 8'd1;
      rc4_pkg::RA_J_NXT: ram_raddr = j_nxt;
      rc4_pkg::RA_T:     ram_raddr = t_addr;
    endcase
    ram_we = uc.we;
  end

  always_comb begin
    step_nxt = step_r;
    n_nxt    = uc.n_inc ? n_r + 1'b1 : n_r;
    k_nxt    = k_r;
    if (uc.k_inc) begin
      k_nxt = (k_plus >= len_eff) ? '0 : k_plus[KW-1:0];
    end
    i_nxt = uc.i_inc ? i_r + 8'd1 : i_r;
    unique case (uc.jc)
      rc4_pkg::JC_NEXT: begin
        step_nxt = rc4_pkg::step_t'(step_r + 1'b1);
      end
      rc4_pkg::JC_ALWAYS: begin
        step_nxt = uc.target;
      end
      rc4_pkg::JC_N_NOT_MAX: begin
        step_nxt = (n_r != '1) ? uc.target : rc4_pkg::step_t'(step_r + 1'b1);
      end
      rc4_pkg::JC_DISPATCH: begin
        if (in_accept) begin
          n_nxt = '0;
          k_nxt = '0;
          priority if (in_ch.op == rc4_pkg::OP_SCHEDULE) begin
            step_nxt = rc4_pkg::STEP_FILL;
          end else if (keyed_r) begin
            step_nxt = rc4_pkg::STEP_D0;
          end else begin
            step_nxt = rc4_pkg::STEP_ERR;
          end
        end
      end
    endcase
    if (hold) begin
      step_nxt = step_r;
    end
    if (uc.finish) begin
      i_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= rc4_pkg::STEP_IDLE;
      keyed_r <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      step_r <= step_nxt;
      n_r    <= n_nxt;
      k_r    <= k_nxt;
      i_r    <= i_nxt;
      j_r    <= uc.finish ? 8'd0 : j_nxt;
      if (uc.finish) begin
        keyed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      din_r  <= in_ch.data_in;
      last_r <= in_ch.last_byte;
    end
    if (uc.si_ld) begin
      si_r <= ram_rdata;
    end
    if (uc.sj_ld) begin
      sj_r <= ram_rdata;
    end
    if (uc.byp_ld) begin
      byp_r <= (t_addr == j_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= rc4_pkg::KEY_LEN_W'(16);
      for (int b = 0; b < KD; b++) begin
        key_r[b] <= '0;
      end
    end else if (cfg_accept) begin
      unique case (cfg_ch.index)
        rc4_pkg::CFG_KEY_LOW, rc4_pkg::CFG_KEY_HIGH: begin
          for (int b = 0; b < KD; b++) begin
            if ((b < MAX_KEY_BYTES) &&
                (cfg_ch.index == ((b < 8) ? rc4_pkg::CFG_KEY_LOW : rc4_pkg::CFG_KEY_HIGH))) begin
              key_r[b] <= cfg_ch.data[8*(b%8) +: 8];
            end
          end
        end
        rc4_pkg::CFG_KEY_LEN: begin
          klen_r <= cfg_ch.data[rc4_pkg::KEY_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uc.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (uc.emit_err && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.emit && out_free) begin
      out_data_r <= din_r ^ ks;
      out_last_r <= last_r;
      out_nk_r   <= 1'b0;
    end else if (uc.emit_err && out_free) begin
      out_data_r <= '0;
      out_last_r <= last_r;
      out_nk_r   <= 1'b1;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.last_out  = out_last_r;
  assign out_ch.not_keyed = out_nk_r;

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::TABLE_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nk_r |-> out_data_r == '0)
    else $error("Error result carries a nonzero byte.");

  a_keyed_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_nk_r |-> keyed_r)
    else $error("Keystream result issued before any key schedule.");

  a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(keyed_r))
    else $error("Key status dropped without reset.");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= rc4_pkg::STEP_LAST)
    else $error("Step counter left the microprogram.");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the RC4 stream cipher core. A scoreboard keeps
// its own permutation table and indices, runs the key schedule on every init
// transaction and predicts each output byte, including the error result for
// data sent before the first key schedule. Random key settings and message
// streams run with random idle cycles on the input and output channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int KEY_BYTES_MAX  = 16;
  localparam int SETTLE_CYCLES  = 1400;
  localparam int HOLD_CYCLES    = 2000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam logic [rc4_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [rc4_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic                       not_keyed;
  } cipher_result_t;

  class keystream_checker;
    logic [rc4_pkg::BYTE_W-1:0]     perm [rc4_pkg::TABLE_DEPTH];
    logic [rc4_pkg::BYTE_W-1:0]     idx_i;
    logic [rc4_pkg::BYTE_W-1:0]     idx_j;
    bit                             keyed;
    logic [rc4_pkg::CFG_DATA_W-1:0] key_lo;
    logic [rc4_pkg::CFG_DATA_W-1:0] key_hi;
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len;
    cipher_result_t                 expected_bytes [$];
    int                             errors;

    function new();
      foreach (perm[n]) perm[n] = '0;
      idx_i   = '0;
      idx_j   = '0;
      keyed   = 1'b0;
      key_lo  = '0;
      key_hi  = '0;
      key_len = 5'd16;
      errors  = 0;
    endfunction

    function void write_register(logic [rc4_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [rc4_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        rc4_pkg::CFG_KEY_LOW:  key_lo = d;
        rc4_pkg::CFG_KEY_HIGH: key_hi = d;
        rc4_pkg::CFG_KEY_LEN:  key_len = d[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [rc4_pkg::BYTE_W-1:0] key_byte(int k);
      int b;
      b = k % 16;
      if (b < 8) return key_lo[8*b +: 8];
      return key_hi[8*(b-8) +: 8];
    endfunction

    function void swap_entries(logic [rc4_pkg::BYTE_W-1:0] a, logic [rc4_pkg::BYTE_W-1:0] b);
      logic [rc4_pkg::BYTE_W-1:0] t;
      t = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    endfunction

    function void run_schedule();
      int len;
      int k;
      logic [rc4_pkg::BYTE_W-1:0] j;
      len = int'(key_len);
      if (len == 0) len = 1;
      if (len > KEY_BYTES_MAX) len = KEY_BYTES_MAX;
      for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) perm[n] = n[rc4_pkg::BYTE_W-1:0];
      j = '0;
      k = 0;
      for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) begin
        j = j + perm[n] + key_byte(k);
        swap_entries(n[rc4_pkg::BYTE_W-1:0], j);
        k++;
        if (k >= len) k = 0;
      end
      idx_i = '0;
      idx_j = '0;
      keyed = 1'b1;
    endfunction

    function void take_item(logic op, logic [rc4_pkg::BYTE_W-1:0] d, logic last);
      cipher_result_t r;
      logic [rc4_pkg::BYTE_W-1:0] t;
      if (op == rc4_pkg::OP_SCHEDULE) begin
        run_schedule();
        return;
      end
      r.last = last;
      if (!keyed) begin
        r.data = '0;
        r.not_keyed = 1'b1;
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        swap_entries(idx_i, idx_j);
        t = perm[idx_i] + perm[idx_j];
        r.data = d ^ perm[t];
        r.not_keyed = 1'b0;
      end
      expected_bytes.push_back(r);
    endfunction

    function void compare_field(string name, logic [rc4_pkg::BYTE_W-1:0] exp,
                                logic [rc4_pkg::BYTE_W-1:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [rc4_pkg::BYTE_W-1:0] d, logic last, logic nk);
      cipher_result_t r;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result transaction, data_out %0h last_out %0b not_keyed %0b",
                 $time, d, last, nk);
        errors++;
        return;
      end
      r = expected_bytes.pop_front();
      compare_field("data_out", r.data, d);
      compare_field("last_out", {7'd0, r.last}, {7'd0, last});
      compare_field("not_keyed", {7'd0, r.not_keyed}, {7'd0, nk});
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  bit   hold_request;
  int   sent;

  keystream_checker sb = new();

  rc4_in_if  in_if();
  rc4_out_if out_if();
  rc4_cfg_if cfg_if();

  rc4_stream_cipher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) sb.write_register(cfg_if.index, cfg_if.data);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.data_out, out_if.last_out, out_if.not_keyed);
    if (rst_n && in_if.valid && in_if.ready)
      sb.take_item(in_if.op, in_if.data_in, in_if.last_byte);
  end

  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic op, input logic [rc4_pkg::BYTE_W-1:0] d,
                           input logic last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.op = op;
    in_if.data_in = d;
    in_if.last_byte = last;
    in_if.valid = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [rc4_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rc4_pkg::CFG_DATA_W-1:0] d);
    repeat (idle_cycles()) @(negedge clk);
    cfg_if.index = idx;
    cfg_if.data = d;
    cfg_if.valid = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic program_key(input logic [rc4_pkg::CFG_DATA_W-1:0] lo,
                             input logic [rc4_pkg::CFG_DATA_W-1:0] hi,
                             input logic [rc4_pkg::CFG_DATA_W-1:0] len);
    write_reg(rc4_pkg::CFG_KEY_LOW, lo);
    write_reg(rc4_pkg::CFG_KEY_HIGH, hi);
    write_reg(rc4_pkg::CFG_KEY_LEN, len);
  endtask

  // A key schedule gives no result, so the core may still be busy after the
  // last expected byte has been taken.
  task automatic settle();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_message(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0)
        send_item(rc4_pkg::OP_SCHEDULE, 8'($urandom), 1'($urandom));
      send_item(rc4_pkg::OP_DATA, 8'($urandom),
                (k == n - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (idle_cycles() > 0) begin
        out_if.ready = 1'b0;
        repeat (idle_cycles()) @(negedge clk);
      end
      out_if.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [rc4_pkg::CFG_DATA_W-1:0] len;
    int r;
    int phase;
    rst_n = 1'b0;
    steady = 1'b0;
    hold_request = 1'b0;
    sent = 0;
    in_if.valid = 1'b0;
    in_if.op = rc4_pkg::OP_DATA;
    in_if.data_in = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = rc4_pkg::CFG_KEY_LOW;
    cfg_if.data = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h5A, 1'b0);
    settle();

    write_reg(CFG_UNUSED, {$urandom, $urandom});
    program_key({64{1'b1}}, '0, 64'd0);
    send_item(rc4_pkg::OP_SCHEDULE, 8'hFF, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hA5, 1'b1);
    settle();

    program_key({$urandom, $urandom}, {$urandom, $urandom}, 64'd31);
    send_item(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_SCHEDULE, 8'h3C, 1'b1);
    repeat (4) send_item(rc4_pkg::OP_DATA, 8'($urandom), 1'($urandom));
    settle();

    program_key({64{1'b1}}, {64{1'b1}}, 64'd16);
    send_item(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h81, 1'b1);
    settle();

    program_key('0, '0, {{59{1'b1}}, 5'd1});
    send_item(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) len = 64'd0;
      else if (r == 1) len = 64'($urandom_range(17, 31));
      else if (r == 2) len = 64'd16;
      else len = 64'($urandom_range(1, 16));
      len[rc4_pkg::CFG_DATA_W-1:rc4_pkg::KEY_LEN_W] =
        (rc4_pkg::CFG_DATA_W - rc4_pkg::KEY_LEN_W)'({$urandom, $urandom});
      program_key({$urandom, $urandom}, {$urandom, $urandom}, len);
      if ($urandom_range(0, 9) != 0)
        send_item(rc4_pkg::OP_SCHEDULE, 8'($urandom), 1'($urandom));
      if (phase == 1 || $urandom_range(0, 11) == 0) hold_request = 1'b1;
      send_message($urandom_range(16, 72));
      phase++;
    end
    steady = 1'b0;
    settle();

    if (sb.errors == 0 && sb.pending() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ rc4_stream_cipher.f @@
rtl/core/rc4_pkg.sv
rtl/core/rc4_in_if.sv
rtl/core/rc4_out_if.sv
rtl/core/rc4_cfg_if.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_stream_cipher.sv
tb/tb.sv
